/* sv/ipv4_source_blocklist_filter_assert.svh */
// Assertion macros shared by the blocklist filter modules
`ifndef IPV4_SOURCE_BLOCKLIST_FILTER_ASSERT_SVH
`define IPV4_SOURCE_BLOCKLIST_FILTER_ASSERT_SVH

// same-cycle implication
`define IPBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ipbf_pkg.sv */
// Shared types and constants of the IPv4 source blocklist filter
package ipbf_pkg;

    localparam int TABLE_SLOTS_DEF = 128;
    localparam int JOB_DEPTH       = 4;

    localparam logic [15:0] TPID_CTAG  = 16'h8100;
    localparam logic [15:0] TPID_STAG  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_INSTALL = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [1:0] OP_PASS    = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_INSTALL = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic        oob;
        logic [31:0] src;
        logic [15:0] len;
        logic [6:0]  idx;
        logic [31:0] addr;
        logic        valid;
    } t_job;

    localparam int JOB_W = $bits(t_job);

endpackage

/* sv/ipbf_parser.sv */
// Front end: frame byte parser and request classifier
module ipbf_parser #(
    parameter int TABLE_SLOTS = ipbf_pkg::TABLE_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_req_type,
    input  logic [7:0]    i_pkt_byte,
    input  logic          i_pkt_last,
    input  logic [6:0]    i_slot_index,
    input  logic [31:0]   i_slot_addr,
    input  logic          i_slot_valid,
    output logic          o_job_push,
    output ipbf_pkg::t_job o_job
);
    import ipbf_pkg::*;

    logic [15:0] r_len, n_len;
    logic [15:0] r_etype, n_etype;
    logic        r_tag, n_tag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [15:0] hdr, hdr_new;
    logic        cand, in_range;

    assign in_range = {4'b0, i_slot_index} < 11'(TABLE_SLOTS);

    always_comb begin
        hdr     = r_tag ? 16'd18 : 16'd14;
        n_etype = r_etype;
        n_proto = r_proto;
        n_src   = r_src;
        if (r_len == 16'd12 || (r_tag && r_len == 16'd16)) begin
            n_etype = {i_pkt_byte, r_etype[7:0]};
        end else if (r_len == 16'd13 || (r_tag && r_len == 16'd17)) begin
            n_etype = {r_etype[15:8], i_pkt_byte};
        end
        n_tag = r_tag | (r_len == 16'd13 && (n_etype inside {TPID_CTAG, TPID_STAG}));
        if (r_len == hdr + 16'd9) begin
            n_proto = i_pkt_byte;
        end else if (r_len inside {[hdr + 16'd12 : hdr + 16'd15]}) begin
            n_src = {r_src[23:0], i_pkt_byte};
        end
        n_len   = (r_len == 16'hFFFF) ? r_len : r_len + 16'd1;
        hdr_new = n_tag ? 16'd18 : 16'd14;
        cand    = n_len >= 16'd14 && n_etype == ETYPE_IPV4 &&
                  {1'b0, n_len} >= {1'b0, hdr_new} + 17'd20 && n_proto != 8'd0;
    end

    always_comb begin
        o_job_push = 1'b0;
        o_job.op    = OP_PASS;
        o_job.oob   = !in_range;
        o_job.src   = n_src;
        o_job.len   = n_len;
        o_job.idx   = i_slot_index;
        o_job.addr  = i_slot_addr;
        o_job.valid = i_slot_valid;
        case (i_req_type)
            REQ_BYTE: begin
                o_job_push = i_accept && i_pkt_last;
                o_job.op   = cand ? OP_LOOKUP : OP_PASS;
            end
            REQ_INSTALL: begin
                o_job_push = i_accept && in_range;
                o_job.op   = OP_INSTALL;
            end
            REQ_READ: begin
                o_job_push = i_accept;
                o_job.op   = OP_READ;
            end
            default: o_job_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_etype <= '0;
            r_tag   <= 1'b0;
            r_proto <= '0;
            r_src   <= '0;
        end else if (i_accept && i_req_type == REQ_BYTE) begin
            if (i_pkt_last) begin
                r_len   <= '0;
                r_etype <= '0;
                r_tag   <= 1'b0;
                r_proto <= '0;
                r_src   <= '0;
            end else begin
                r_len   <= n_len;
                r_etype <= n_etype;
                r_tag   <= n_tag;
                r_proto <= n_proto;
                r_src   <= n_src;
            end
        end
    end

endmodule

/* sv/ipbf_fifo.sv */
// Short job queue between parser and lookup engine
`include "ipv4_source_blocklist_filter_assert.svh"
module ipbf_fifo #(
    parameter int DEPTH = ipbf_pkg::JOB_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ipbf_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ipbf_pkg::t_job  o_data
);
    import ipbf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    logic            wr, rd;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    `IPBF_ASSERT_NOW(a_no_push_full, o_full, !wr, "job queue written while full")
    `IPBF_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= (AW+1)'(DEPTH), "job count overflow")
    `IPBF_ASSERT_NEXT(a_cnt_step, wr && !rd, r_cnt == $past(r_cnt) + 1'b1, "lost write")

endmodule

/* sv/ipbf_engine.sv */
// Back end: table memories, slot scan, counter update and result register
`include "ipv4_source_blocklist_filter_assert.svh"
module ipbf_engine #(
    parameter int TABLE_SLOTS = ipbf_pkg::TABLE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  ipbf_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_resp_kind,
    output logic           o_verdict,
    output logic [6:0]     o_hit_slot,
    output logic [31:0]    o_packet_count,
    output logic [47:0]    o_byte_count
);
    import ipbf_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_CNT  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [31:0] addr_mem [TABLE_SLOTS];
    logic [31:0] pkt_mem  [TABLE_SLOTS];
    logic [47:0] byte_mem [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] r_valid, r_written;
    logic [1:0]  r_state, n_state;
    logic [SW-1:0] r_rd_slot, n_rd_slot, cnt_addr, job_slot;
    logic [31:0] r_addr_q, r_pkt_q;
    logic [47:0] r_byte_q;
    logic        r_wr_q;
    logic        r_res_verdict, r_res_kind;
    logic [6:0]  r_res_slot;
    logic [31:0] r_res_pkt, new_pkt;
    logic [47:0] r_res_byte, new_byte;
    logic        r_out_valid, out_free, emit, match, cnt_we, inst_we;

    assign job_slot = SW'(i_job.idx);
    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_state == S_EMIT && out_free;
    assign match    = r_valid[r_rd_slot] && r_addr_q == i_job.src;
    assign new_pkt  = r_pkt_q + 32'd1;
    assign new_byte = r_byte_q + {32'b0, i_job.len};
    assign inst_we  = r_state == S_IDLE && !i_job_empty && i_job.op == OP_INSTALL;
    assign cnt_we   = r_state == S_CNT && i_job.op == OP_LOOKUP;
    assign o_job_pop = emit || inst_we;
    assign cnt_addr  = (r_state == S_IDLE) ? job_slot : r_rd_slot;

    always_comb begin
        n_state   = r_state;
        n_rd_slot = r_rd_slot;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    case (i_job.op)
                        OP_LOOKUP: begin
                            n_state   = S_SCAN;
                            n_rd_slot = '0;
                        end
                        OP_READ: n_state = i_job.oob ? S_EMIT : S_CNT;
                        OP_PASS: n_state = S_EMIT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = S_CNT;
                end else if (r_rd_slot == SW'(TABLE_SLOTS-1)) begin
                    n_state = S_EMIT;
                end else begin
                    n_rd_slot = r_rd_slot + 1'b1;
                end
            end
            S_CNT:   n_state = S_EMIT;
            S_EMIT:  n_state = out_free ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_addr_q <= addr_mem[n_rd_slot];
        r_pkt_q  <= pkt_mem[cnt_addr];
        r_byte_q <= byte_mem[cnt_addr];
        r_wr_q   <= r_written[cnt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (inst_we) begin
            addr_mem[job_slot] <= i_job.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (inst_we) begin
            pkt_mem[job_slot]  <= '0;
            byte_mem[job_slot] <= '0;
        end else if (cnt_we) begin
            pkt_mem[r_rd_slot]  <= new_pkt;
            byte_mem[r_rd_slot] <= new_byte;
        end
    end

    // result staging
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_res_kind    <= i_job.op == OP_READ;
            r_res_verdict <= 1'b0;
            r_res_slot    <= (i_job.op == OP_READ) ? i_job.idx : 7'd0;
            r_res_pkt     <= '0;
            r_res_byte    <= '0;
        end else if (r_state == S_CNT) begin
            if (i_job.op == OP_LOOKUP) begin
                r_res_verdict <= 1'b1;
                r_res_slot    <= 7'(r_rd_slot);
                r_res_pkt     <= new_pkt;
                r_res_byte    <= new_byte;
            end else begin
                r_res_pkt  <= r_wr_q ? r_pkt_q : '0;
                r_res_byte <= r_wr_q ? r_byte_q : '0;
            end
        end
        if (emit) begin
            o_resp_kind    <= r_res_kind;
            o_verdict      <= r_res_verdict;
            o_hit_slot     <= r_res_slot;
            o_packet_count <= r_res_pkt;
            o_byte_count   <= r_res_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_slot   <= '0;
            r_valid     <= '0;
            r_written   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_slot <= n_rd_slot;
            if (inst_we) begin
                r_valid[job_slot]   <= i_job.valid;
                r_written[job_slot] <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;

    `IPBF_ASSERT_NOW(a_scan_op, r_state == S_SCAN, i_job.op == OP_LOOKUP && !i_job_empty, "scan without lookup job")
    `IPBF_ASSERT_NOW(a_cnt_op, r_state == S_CNT, i_job.op == OP_LOOKUP || i_job.op == OP_READ, "counter step on wrong job")
    `IPBF_ASSERT_NEXT(a_out_hold, r_out_valid && !i_pop, r_out_valid && $stable(o_byte_count), "result beat lost")
    `IPBF_ASSERT_NOW(a_hit_valid, cnt_we, r_written[r_rd_slot], "hit on never-installed slot")

endmodule

/* sv/ipv4_source_blocklist_filter.sv */
// Top level of the IPv4 source blocklist filter
// Frame bytes, slot installs and counter reads enter through a queue-style port at up to one
// beat per cycle while push sees full low; the parser counts frame length, picks out the
// EtherType (skipping one VLAN tag), IP protocol and source address, and hands one job per
// frame, in-range install or read to a four-entry job queue. The back-end engine works one
// job at a time: a lookup scans the address memory one slot per cycle, lowest slot first (a
// miss costs the full scan), a hit then does the counter read-modify-write, and an install is
// written from the idle state. Results wait in an output register until popped. Valid bits
// are flip-flops, so no clearing pass follows reset.
module ipv4_source_blocklist_filter #(
    parameter int TABLE_SLOTS = ipbf_pkg::TABLE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_pkt_byte,
    input  logic        i_pkt_last,
    input  logic [6:0]  i_slot_index,
    input  logic [31:0] i_slot_addr,
    input  logic        i_slot_valid,
    output logic        empty,
    input  logic        pop,
    output logic        o_resp_kind,
    output logic        o_verdict,
    output logic [6:0]  o_hit_slot,
    output logic [31:0] o_packet_count,
    output logic [47:0] o_byte_count
);
    import ipbf_pkg::*;

    t_job job_in, job_head;
    logic job_push, job_pop, job_empty, accept;

    assign accept = push && !full;

    ipbf_parser #(.TABLE_SLOTS(TABLE_SLOTS)) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req_type   (i_req_type),
        .i_pkt_byte   (i_pkt_byte),
        .i_pkt_last   (i_pkt_last),
        .i_slot_index (i_slot_index),
        .i_slot_addr  (i_slot_addr),
        .i_slot_valid (i_slot_valid),
        .o_job_push   (job_push),
        .o_job        (job_in)
    );

    ipbf_fifo #(.DEPTH(JOB_DEPTH)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_head)
    );

    ipbf_engine #(.TABLE_SLOTS(TABLE_SLOTS)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_empty    (job_empty),
        .i_job          (job_head),
        .o_job_pop      (job_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_resp_kind    (o_resp_kind),
        .o_verdict      (o_verdict),
        .o_hit_slot     (o_hit_slot),
        .o_packet_count (o_packet_count),
        .o_byte_count   (o_byte_count)
    );

endmodule

/* tb/ipv4_source_blocklist_filter_tb.sv */
// Self-checking testbench of the IPv4 source blocklist filter
module ipv4_source_blocklist_filter_tb;
    import ipbf_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SLOTS = 128;
    localparam int IDLE_PCT = 29;
    localparam int TOTAL_BEATS = 1650;

    typedef enum int {
        F_PLAIN, F_TAG_Q, F_TAG_AD, F_SHORT, F_NOT_IP, F_TRUNC, F_PROTO0, F_DOUBLE_TAG
    } t_frame_form;

    typedef struct {
        logic        kind;
        logic        verdict;
        logic [6:0]  slot;
        logic [31:0] pkts;
        logic [47:0] bytes;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_req_type;
    logic [7:0]  i_pkt_byte;
    logic        i_pkt_last;
    logic [6:0]  i_slot_index;
    logic [31:0] i_slot_addr;
    logic        i_slot_valid;
    logic        empty;
    logic        pop;
    logic        o_resp_kind;
    logic        o_verdict;
    logic [6:0]  o_hit_slot;
    logic [31:0] o_packet_count;
    logic [47:0] o_byte_count;

    ipv4_source_blocklist_filter dut (.*);

    // per-frame parser state
    logic [15:0] frm_len;
    logic [15:0] frm_type;
    logic        frm_tagged;
    logic [7:0]  frm_proto;
    logic [31:0] frm_src;
    // blocklist table
    logic        blk_valid [SLOTS];
    logic [31:0] blk_addr  [SLOTS];
    logic [31:0] blk_pkts  [SLOTS];
    logic [47:0] blk_bytes [SLOTS];

    t_verdict    pending_verdicts[$];
    logic [31:0] blocked_addrs[$];
    int          errors;
    int          beats_sent;
    int          send_idle_pct;
    int          pop_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("ipv4_source_blocklist_filter_tb: FAIL");
        $finish;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic void clear_frame_state();
        frm_len    = '0;
        frm_type   = '0;
        frm_tagged = 1'b0;
        frm_proto  = '0;
        frm_src    = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int pos;
        int hdr;
        pos = int'(frm_len);
        hdr = frm_tagged ? 18 : 14;
        if (pos == 12 || (frm_tagged && pos == 16))
            frm_type = {b, frm_type[7:0]};
        else if (pos == 13 || (frm_tagged && pos == 17))
            frm_type = {frm_type[15:8], b};
        if (pos == 13 && (frm_type inside {TPID_CTAG, TPID_STAG}))
            frm_tagged = 1'b1;
        if (pos == hdr + 9)
            frm_proto = b;
        else if (pos inside {[hdr + 12 : hdr + 15]})
            frm_src = {frm_src[23:0], b};
        if (frm_len != 16'hFFFF)
            frm_len++;
    endfunction

    // predicts the response (if any) for one accepted beat
    function automatic void predict_beat(input logic [1:0] req, input logic [7:0] b,
                                         input logic last, input logic [6:0] idx,
                                         input logic [31:0] addr, input logic vld);
        t_verdict v;
        int hdr;
        bit hit;
        v = '{1'b0, 1'b0, 7'd0, 32'd0, 48'd0};
        case (req)
            REQ_INSTALL: begin
                blk_addr[idx]  = addr;
                blk_valid[idx] = vld;
                blk_pkts[idx]  = '0;
                blk_bytes[idx] = '0;
            end
            REQ_READ: begin
                v = '{1'b1, 1'b0, idx, blk_pkts[idx], blk_bytes[idx]};
                pending_verdicts.push_back(v);
            end
            REQ_BYTE: begin
                parse_byte(b);
                if (last) begin
                    hdr = frm_tagged ? 18 : 14;
                    hit = 1'b0;
                    if (frm_len >= 14 && frm_type == ETYPE_IPV4 && frm_len >= hdr + 20
                        && frm_proto != 0) begin
                        for (int s = 0; s < SLOTS && !hit; s++) begin
                            if (blk_valid[s] && blk_addr[s] == frm_src) begin
                                hit = 1'b1;
                                blk_pkts[s]  = blk_pkts[s] + 32'd1;
                                blk_bytes[s] = blk_bytes[s] + {32'd0, frm_len};
                                v = '{1'b0, 1'b1, s[6:0], blk_pkts[s], blk_bytes[s]};
                            end
                        end
                    end
                    pending_verdicts.push_back(v);
                    clear_frame_state();
                end
            end
            default: ;
        endcase
    endfunction

    // one beat into the block; called just after a rising edge
    task automatic send_beat(input logic [1:0] req, input logic [7:0] b, input logic last,
                             input logic [6:0] idx, input logic [31:0] addr,
                             input logic vld);
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push         <= 1'b1;
        i_req_type   <= req;
        i_pkt_byte   <= b;
        i_pkt_last   <= last;
        i_slot_index <= idx;
        i_slot_addr  <= addr;
        i_slot_valid <= vld;
        do @(posedge i_clk); while (full);
        predict_beat(req, b, last, idx, addr, vld);
        beats_sent++;
    endtask

    task automatic install_slot(input logic [6:0] idx, input logic [31:0] addr,
                                input logic vld);
        send_beat(REQ_INSTALL, 8'($urandom), 1'($urandom), idx, addr, vld);
        if (vld)
            blocked_addrs.push_back(addr);
    endtask

    task automatic read_slot(input logic [6:0] idx);
        send_beat(REQ_READ, 8'($urandom), 1'($urandom), idx, $urandom, 1'($urandom));
    endtask

    task automatic send_frame(ref logic [7:0] f[$]);
        foreach (f[i])
            send_beat(REQ_BYTE, f[i], i == f.size() - 1, 7'($urandom), $urandom,
                      1'($urandom));
    endtask

    function automatic void build_frame(ref logic [7:0] f[$], input t_frame_form form,
                                        input logic [31:0] src, input int pay);
        f.delete();
        if (form == F_SHORT) begin
            repeat ($urandom_range(1, 13)) f.push_back(8'($urandom));
            return;
        end
        repeat (12) f.push_back(8'($urandom));
        if (form == F_TAG_Q || form == F_DOUBLE_TAG) begin
            f.push_back(8'h81); f.push_back(8'h00);
            f.push_back(8'($urandom)); f.push_back(8'($urandom));
        end else if (form == F_TAG_AD) begin
            f.push_back(8'h88); f.push_back(8'hA8);
            f.push_back(8'($urandom)); f.push_back(8'($urandom));
        end
        if (form == F_NOT_IP) begin
            f.push_back(8'h86); f.push_back(8'hDD);
        end else if (form == F_DOUBLE_TAG) begin
            f.push_back(8'h81); f.push_back(8'h00);
        end else begin
            f.push_back(8'h08); f.push_back(8'h00);
        end
        f.push_back(8'h45);
        repeat (8) f.push_back(8'($urandom));
        f.push_back(form == F_PROTO0 ? 8'd0 : 8'($urandom_range(1, 255)));
        repeat (2) f.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) f.push_back(src[8*i +: 8]);
        repeat (4) f.push_back(8'($urandom));
        if (form == F_TRUNC)
            repeat ($urandom_range(1, 20)) void'(f.pop_back());
        else
            repeat (pay) f.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] pick_source();
        if (blocked_addrs.size() > 0 && $urandom_range(99) < 70)
            return blocked_addrs[$urandom_range(blocked_addrs.size() - 1)];
        return $urandom;
    endfunction

    // result side: random pop, compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (pop && !empty) begin
            if (pending_verdicts.size() == 0) begin
                report("response with nothing expected");
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (o_resp_kind !== exp_v.kind)
                    report($sformatf("resp_kind %0b exp %0b", o_resp_kind, exp_v.kind));
                if (o_verdict !== exp_v.verdict)
                    report($sformatf("verdict %0b exp %0b", o_verdict, exp_v.verdict));
                if (o_hit_slot !== exp_v.slot)
                    report($sformatf("hit_slot %0d exp %0d", o_hit_slot, exp_v.slot));
                if (o_packet_count !== exp_v.pkts)
                    report($sformatf("packet_count %0d exp %0d", o_packet_count, exp_v.pkts));
                if (o_byte_count !== exp_v.bytes)
                    report($sformatf("byte_count %0d exp %0d", o_byte_count, exp_v.bytes));
            end
        end
        pop <= i_rst_n && ($urandom_range(99) >= pop_idle_pct);
    end

    task automatic test_reset_reads();
        read_slot(7'd0);
        read_slot(7'd127);
        install_slot(7'd127, 32'hFFFF_FFFF, 1'b1);
        install_slot(7'd0, 32'h0000_0000, 1'b1);
        send_beat(REQ_UNUSED, 8'hFF, 1'b1, 7'h7F, 32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_frame_forms();
        logic [7:0] f[$];
        t_frame_form form;
        install_slot(7'd5, 32'hC0A8_0101, 1'b1);
        install_slot(7'd2, 32'hC0A8_0101, 1'b1);  // lower slot must win
        form = form.first();
        do begin
            build_frame(f, form, 32'hC0A8_0101, $urandom_range(0, 6));
            send_frame(f);
            form = form.next();
        end while (form != form.first());
        build_frame(f, F_PLAIN, 32'hFFFF_FFFF, 0);
        send_frame(f);
        build_frame(f, F_PLAIN, 32'h0000_0000, 0);
        send_frame(f);
        install_slot(7'd2, 32'hC0A8_0101, 1'b0);  // removal leaves slot 5
        build_frame(f, F_TAG_AD, 32'hC0A8_0101, 1);
        send_frame(f);
        read_slot(7'd2);
        read_slot(7'd5);
        read_slot(7'd127);
    endtask

    task automatic test_random();
        logic [7:0] f[$];
        int target;
        int pick;
        target = TOTAL_BEATS;
        while (beats_sent < target) begin
            if (beats_sent > target - 400 && beats_sent < target - 200) begin
                send_idle_pct = 0;
                pop_idle_pct  = 0;
            end else begin
                send_idle_pct = IDLE_PCT;
                pop_idle_pct  = IDLE_PCT;
            end
            pick = $urandom_range(99);
            if (pick < 12)
                install_slot(7'($urandom),
                             $urandom_range(99) < 50 ? pick_source() : $urandom,
                             $urandom_range(99) < 85);
            else if (pick < 25)
                read_slot(7'($urandom));
            else if (pick < 28)
                send_beat(REQ_UNUSED, 8'($urandom), 1'($urandom), 7'($urandom), $urandom,
                          1'($urandom));
            else if (pick < 85) begin
                build_frame(f, t_frame_form'($urandom_range(0, 2)), pick_source(),
                            $urandom_range(0, 12));
                send_frame(f);
            end else begin
                build_frame(f, t_frame_form'($urandom_range(0, 7)), pick_source(),
                            $urandom_range(0, 8));
                send_frame(f);
            end
        end
    endtask

    initial begin
        int wait_cycles;
        errors        = 0;
        beats_sent    = 0;
        send_idle_pct = IDLE_PCT;
        pop_idle_pct  = IDLE_PCT;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_req_type    = REQ_BYTE;
        i_pkt_byte    = '0;
        i_pkt_last    = 1'b0;
        i_slot_index  = '0;
        i_slot_addr   = '0;
        i_slot_valid  = 1'b0;
        clear_frame_state();
        for (int s = 0; s < SLOTS; s++) begin
            blk_valid[s] = 1'b0;
            blk_addr[s]  = '0;
            blk_pkts[s]  = '0;
            blk_bytes[s] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_reads();
        test_frame_forms();
        test_random();
        push <= 1'b0;

        wait_cycles = 0;
        while (pending_verdicts.size() != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("ipv4_source_blocklist_filter_tb: PASS");
        end else begin
            $display("ipv4_source_blocklist_filter_tb: FAIL");
        end
        $finish;
    end

endmodule
